// ----- rtl/pcap_pkg.sv -----
package pcap_pkg;

  // Fixed-point widths: Q16.16 samples and means, Q2.30 coefficients
  localparam int VALUE_W     = 32;
  localparam int CENTER_W    = VALUE_W + 1;
  localparam int PROD_W      = 64;
  localparam int ROUND_SHIFT = 30;
  localparam int TERM_W      = PROD_W + 1 - ROUND_SHIFT;
  localparam int ACC_W       = 64;
  localparam int OUT_W       = 48;

  // Request kinds carried in the input sideband
  typedef enum logic [1:0] {
    FUNC_MEAN   = 2'd0,
    FUNC_COEF   = 2'd1,
    FUNC_SAMPLE = 2'd2
  } func_t;

  // Configuration register indexes
  localparam logic REG_FEATURE_COUNT   = 1'b0;
  localparam logic REG_COMPONENT_COUNT = 1'b1;

endpackage

// ----- rtl/pcap_mac.sv -----
module pcap_mac #(
  parameter int CW = 4
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  input  logic [CW-1:0]                       in_k,
  input  logic signed [pcap_pkg::CENTER_W-1:0] centered,
  input  logic signed [pcap_pkg::VALUE_W-1:0]  coef,
  input  logic signed [pcap_pkg::ACC_W-1:0]    acc,
  output logic                                wr_en,
  output logic [CW-1:0]                       wr_k,
  output logic signed [pcap_pkg::ACC_W-1:0]    wr_data,
  output logic                                busy
);

  localparam int PW = pcap_pkg::PROD_W;
  localparam int AW = pcap_pkg::ACC_W;

  logic signed [pcap_pkg::CENTER_W+pcap_pkg::VALUE_W-1:0] prod_full;
  logic signed [PW-1:0]                 prod_q;
  logic signed [AW-1:0]                 acc1;
  logic                                 v1;
  logic [CW-1:0]                        k1;
  logic signed [PW:0]                   rnd;
  logic signed [pcap_pkg::TERM_W-1:0]   term_q;
  logic signed [AW-1:0]                 acc2;
  logic                                 v2;
  logic [CW-1:0]                        k2;
  logic signed [AW:0]                   sum;

  // Exact product of centered value and coefficient, fits 64 bits
  assign prod_full = centered * coef;

  // Round half up to Q.16: add half an LSB, then floor by arithmetic shift
  assign rnd = {prod_q[PW-1], prod_q} + (PW+1)'(64'd1 << (pcap_pkg::ROUND_SHIFT - 1));

  // Stage one: multiply; stage two: round
  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
    end else begin
      v1 <= in_valid;
      v2 <= v1;
    end
    prod_q <= prod_full[PW-1:0];
    acc1   <= acc;
    k1     <= in_k;
    term_q <= rnd[PW:pcap_pkg::ROUND_SHIFT];
    acc2   <= acc1;
    k2     <= k1;
  end

  // Saturating accumulate, written back by the accumulator bank
  assign sum = {acc2[AW-1], acc2} + (AW+1)'(term_q);

  always_comb begin
    if (sum[AW] != sum[AW-1]) begin
      wr_data = sum[AW] ? {1'b1, {(AW-1){1'b0}}} : {1'b0, {(AW-1){1'b1}}};
    end else begin
      wr_data = sum[AW-1:0];
    end
  end

  assign wr_en = v2;
  assign wr_k  = k2;
  assign busy  = v1 | v2;

endmodule

// ----- rtl/pcap_acc_bank.sv -----
module pcap_acc_bank #(
  parameter int DEPTH = 16,
  parameter int AW    = 4
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              clear,
  input  logic                              wr_en,
  input  logic [AW-1:0]                     wr_addr,
  input  logic signed [pcap_pkg::ACC_W-1:0]  wr_data,
  input  logic [AW-1:0]                     rd_addr,
  output logic signed [pcap_pkg::ACC_W-1:0]  rd_data
);

  logic [pcap_pkg::ACC_W-1:0] mem [DEPTH];
  logic [DEPTH-1:0]           valid;
  logic [pcap_pkg::ACC_W-1:0] rd_q;
  logic                       rd_vld_q;

  // Accumulator storage with registered read
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_q <= mem[rd_addr];
  end

  // Valid bits: an entry not written since the last clear reads as zero
  always_ff @(posedge clk) begin
    if (rst || clear) begin
      valid <= '0;
    end else if (wr_en) begin
      valid[wr_addr] <= 1'b1;
    end
    rd_vld_q <= valid[rd_addr];
  end

  assign rd_data = rd_vld_q ? rd_q : '0;

endmodule

// ----- rtl/pca_projection.sv -----
// Projects sample rows onto fitted components. A mean or coefficient load
// is written when accepted. After a sample element is accepted, no new
// request is taken until it is done: its mean is fetched, it is centered,
// each kept component in turn goes through the single shared multiply /
// round / saturating-accumulate pipeline, and that pipeline drains. The
// element with the last feature index then emits one result per
// component, each held through any output stall, the final one marked with
// tlast, and clears the accumulators. Reading a mean or coefficient that
// was never loaded gives an undefined result.
module pca_projection #(
  parameter int MAX_FEATURES   = 1024,
  parameter int MAX_COMPONENTS = 16
) (
  input  logic        clk,
  input  logic        rst,
  // Input stream
  input  logic        s_tvalid,
  output logic        s_tready,
  // [9:0] feature_index, [13:10] component_index, [45:14] value, [47:46] zero
  input  logic [47:0] s_tdata,
  // [1:0] func
  input  logic [1:0]  s_tuser,
  // Result stream
  output logic        m_tvalid,
  input  logic        m_tready,
  // [3:0] component_number, [51:4] projected_value, [55:52] zero
  output logic [55:0] m_tdata,
  output logic        m_tlast,
  // Configuration port
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int FW          = (MAX_FEATURES > 1) ? $clog2(MAX_FEATURES) : 1;
  localparam int CW          = (MAX_COMPONENTS > 1) ? $clog2(MAX_COMPONENTS) : 1;
  localparam int IW          = (FW > 10) ? FW : 10;
  localparam int CIW         = (CW > 4) ? CW : 4;
  localparam int COEF_DEPTH  = MAX_COMPONENTS << FW;
  localparam logic [31:0] MAXF32 = 32'(MAX_FEATURES);
  localparam logic [31:0] MAXC32 = 32'(MAX_COMPONENTS);
  localparam int VW          = pcap_pkg::VALUE_W;
  localparam int OW          = pcap_pkg::OUT_W;
  localparam int AW          = pcap_pkg::ACC_W;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MEAN,
    ST_RUN,
    ST_DRAIN,
    ST_EMIT_RD,
    ST_EMIT_WAIT
  } state_t;

  state_t state;

  // Configuration registers
  logic [10:0] feature_count;
  logic [4:0]  component_count;

  // Unpacked request fields
  logic [9:0]          in_fi;
  logic [3:0]          in_ci;
  logic [VW-1:0]       in_value;
  logic [IW-1:0]       fi_ext;
  logic [CIW-1:0]      ci_ext;
  logic [FW-1:0]       f_idx;
  logic [CW-1:0]       c_idx;
  logic                accept;
  logic                mean_ok;
  logic                coef_ok;
  logic                sample_ok;
  logic                row_end;
  logic [31:0]         fc32;
  logic [31:0]         cc32;
  logic [31:0]         nf32;
  logic [31:0]         nc32;
  logic [CW-1:0]       nc_m1;

  // Stores
  logic [VW-1:0] mean_mem [MAX_FEATURES];
  logic [VW-1:0] coef_mem [COEF_DEPTH];
  logic [VW-1:0] mean_q;
  logic [VW-1:0] coef_q;

  // Sequencer state
  logic [FW-1:0]                         f_q;
  logic [VW-1:0]                         sample_q;
  logic                                  row_end_q;
  logic signed [pcap_pkg::CENTER_W-1:0]  centered;
  logic [CW-1:0]                         k;
  logic [CIW-1:0]                        k_ext;
  logic                                  s1_valid;
  logic [CW-1:0]                         s1_k;
  logic                                  out_free;
  logic                                  acc_clear;

  // Shared unit and accumulator bank
  logic                  mac_wr_en;
  logic [CW-1:0]         mac_wr_k;
  logic signed [AW-1:0]  mac_wr_data;
  logic                  mac_busy;
  logic signed [AW-1:0]  acc_rd;
  logic [OW-1:0]         acc_sat;

  // Output register
  logic                  out_valid;
  logic [3:0]            out_number;
  logic [OW-1:0]         out_value;
  logic                  out_last;

  // Field decode
  assign in_fi    = s_tdata[9:0];
  assign in_ci    = s_tdata[13:10];
  assign in_value = s_tdata[45:14];
  assign fi_ext   = IW'(in_fi);
  assign ci_ext   = CIW'(in_ci);
  assign f_idx    = fi_ext[FW-1:0];
  assign c_idx    = ci_ext[CW-1:0];
  assign accept   = s_tvalid && s_tready;
  assign s_tready = (state == ST_IDLE);

  // Clamp the row geometry to the store sizes, treating a zero count as one
  assign fc32  = 32'(feature_count);
  assign cc32  = 32'(component_count);
  assign nf32  = (fc32 == 32'd0) ? 32'd1 : ((fc32 > MAXF32) ? MAXF32 : fc32);
  assign nc32  = (cc32 == 32'd0) ? 32'd1 : ((cc32 > MAXC32) ? MAXC32 : cc32);
  assign nc_m1 = CW'(nc32 - 32'd1);

  assign mean_ok   = 32'(in_fi) < MAXF32;
  assign coef_ok   = (32'(in_fi) < MAXF32) && (32'(in_ci) < MAXC32);
  assign sample_ok = 32'(in_fi) < nf32;
  assign row_end   = 32'(in_fi) == (nf32 - 32'd1);

  // Configuration writes and reads
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      feature_count   <= 11'd1;
      component_count <= 5'd1;
    end else if (psel && penable && pwrite && pready) begin
      unique case (paddr[2])
        pcap_pkg::REG_FEATURE_COUNT:   feature_count   <= pwdata[10:0];
        pcap_pkg::REG_COMPONENT_COUNT: component_count <= pwdata[4:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[2])
      pcap_pkg::REG_FEATURE_COUNT:   prdata = 32'(feature_count);
      pcap_pkg::REG_COMPONENT_COUNT: prdata = 32'(component_count);
      default:                       prdata = '0;
    endcase
  end

  // Mean store: load on request, read at the accepted feature
  always_ff @(posedge clk) begin
    if (accept && (pcap_pkg::func_t'(s_tuser) == pcap_pkg::FUNC_MEAN) && mean_ok) begin
      mean_mem[f_idx] <= in_value;
    end
    mean_q <= mean_mem[f_idx];
  end

  // Coefficient store: component-major rows, read one component per cycle
  always_ff @(posedge clk) begin
    if (accept && (pcap_pkg::func_t'(s_tuser) == pcap_pkg::FUNC_COEF) && coef_ok) begin
      coef_mem[{c_idx, f_idx}] <= in_value;
    end
    coef_q <= coef_mem[{k, f_q}];
  end

  pcap_mac #(
    .CW (CW)
  ) u_mac (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s1_valid),
    .in_k     (s1_k),
    .centered (centered),
    .coef     (coef_q),
    .acc      (acc_rd),
    .wr_en    (mac_wr_en),
    .wr_k     (mac_wr_k),
    .wr_data  (mac_wr_data),
    .busy     (mac_busy)
  );

  pcap_acc_bank #(
    .DEPTH (MAX_COMPONENTS),
    .AW    (CW)
  ) u_acc (
    .clk     (clk),
    .rst     (rst),
    .clear   (acc_clear),
    .wr_en   (mac_wr_en),
    .wr_addr (mac_wr_k),
    .wr_data (mac_wr_data),
    .rd_addr (k),
    .rd_data (acc_rd)
  );

  // Saturate the accumulator to the output range
  always_comb begin
    if (acc_rd[AW-1:OW-1] == {(AW-OW+1){acc_rd[AW-1]}}) begin
      acc_sat = acc_rd[OW-1:0];
    end else if (acc_rd[AW-1]) begin
      acc_sat = {1'b1, {(OW-1){1'b0}}};
    end else begin
      acc_sat = {1'b0, {(OW-1){1'b1}}};
    end
  end

  assign k_ext     = CIW'(k);
  assign out_free  = !out_valid || m_tready;
  assign acc_clear = (state == ST_EMIT_WAIT) && out_free && (k == nc_m1);

  // Sequencer and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      k         <= '0;
      s1_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      s1_valid <= (state == ST_RUN);
      // Load the output register, or drop it once taken
      if ((state == ST_EMIT_WAIT) && out_free) begin
        out_valid <= 1'b1;
      end else if (out_valid && m_tready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (accept && (pcap_pkg::func_t'(s_tuser) == pcap_pkg::FUNC_SAMPLE) && sample_ok) begin
            state <= ST_MEAN;
          end
        end
        ST_MEAN: begin
          k     <= '0;
          state <= ST_RUN;
        end
        ST_RUN: begin
          if (k == nc_m1) begin
            state <= ST_DRAIN;
          end else begin
            k <= k + 1'b1;
          end
        end
        ST_DRAIN: begin
          if (!s1_valid && !mac_busy) begin
            k     <= '0;
            state <= row_end_q ? ST_EMIT_RD : ST_IDLE;
          end
        end
        ST_EMIT_RD: begin
          state <= ST_EMIT_WAIT;
        end
        ST_EMIT_WAIT: begin
          if (out_free) begin
            if (k == nc_m1) begin
              state <= ST_IDLE;
            end else begin
              k     <= k + 1'b1;
              state <= ST_EMIT_RD;
            end
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
    // Payload: hold the accepted sample, center it, load results
    s1_k <= k;
    if (accept) begin
      f_q       <= f_idx;
      sample_q  <= in_value;
      row_end_q <= row_end;
    end
    if (state == ST_MEAN) begin
      centered <= $signed({sample_q[VW-1], sample_q}) - $signed({mean_q[VW-1], mean_q});
    end
    if ((state == ST_EMIT_WAIT) && out_free) begin
      out_number <= k_ext[3:0];
      out_value  <= acc_sat;
      out_last   <= (k == nc_m1);
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = {4'd0, out_value, out_number};
  assign m_tlast  = out_last;

endmodule
